FILE: sv/pwa_pkg.sv
// Shared types and constants for the point window average block.
package pwa_pkg;

    localparam int COORD_BITS   = 12;
    localparam int COUNT_OUT_W  = 5;
    localparam int LEN_W        = 5;
    localparam int MAX_WINDOW_D = 16;
    localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd10;

    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_MISS   = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } pwa_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  mean_x;
        logic [COORD_BITS-1:0]  mean_y;
        logic [COUNT_OUT_W-1:0] held_count;
        logic                   mean_valid;
    } pwa_out_t;

endpackage

FILE: sv/point_window_average.sv
// Top level: sliding-window mean of a tracked point over a circular buffer memory.
// Steps per transaction: read, update, divide (bit-serial divider), emit; the divide step
//   is skipped when the window ends up empty. A new transaction is accepted only once the
//   previous one has been emitted, which out_stall can hold back.
// Reset: window empty, write index zero, sums zero, window_length 10; the point
//   memory is not cleared, only held slots are ever used.
module point_window_average #(
    parameter int MAX_WINDOW = pwa_pkg::MAX_WINDOW_D
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  pwa_pkg::pwa_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output pwa_pkg::pwa_out_t         out_data,
    input  logic                      cfg_we,
    input  logic [pwa_pkg::LEN_W-1:0] cfg_data
);

    localparam int C  = pwa_pkg::COORD_BITS;
    localparam int IW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = C + IW;
    localparam int EW = (CW > pwa_pkg::LEN_W) ? CW : pwa_pkg::LEN_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_WAIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [pwa_pkg::LEN_W-1:0] wlen_reg;
    logic [IW-1:0]             wi_reg, wi_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [SW-1:0]             sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic                      op_reg, drop_reg, drop_next;
    logic [C-1:0]              px_reg, py_reg;
    logic                      out_valid_reg;
    pwa_pkg::pwa_out_t         out_data_reg, out_data_next;

    logic [2*C-1:0] mem [MAX_WINDOW];
    logic [2*C-1:0] rd_reg;
    logic [IW-1:0]  rd_addr;
    logic [IW+1:0]  slot_tmp;
    logic           mem_we;

    logic [EW-1:0] eff_len;
    logic          accept, out_free, load_out;
    logic          div_start, div_done;
    logic [SW-1:0] quot_x, quot_y;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_WAIT) && out_free;

    always_comb
    begin
        if (wlen_reg == '0)
            eff_len = EW'(1);
        else if (EW'(wlen_reg) > EW'(MAX_WINDOW))
            eff_len = EW'(MAX_WINDOW);
        else
            eff_len = EW'(wlen_reg);
    end

    // oldest slot = (write index - count) mod MAX_WINDOW
    always_comb
    begin
        slot_tmp = (IW+2)'(wi_reg) + (IW+2)'(MAX_WINDOW) - (IW+2)'(count_reg);
        if (slot_tmp >= (IW+2)'(MAX_WINDOW))
            slot_tmp = slot_tmp - (IW+2)'(MAX_WINDOW);
        rd_addr = IW'(slot_tmp);
    end

    always_comb
    begin
        if (in_data.opcode == pwa_pkg::OP_DETECT)
            drop_next = ((EW+1)'(count_reg) + (EW+1)'(1) > (EW+1)'(eff_len))
                        || (count_reg >= CW'(MAX_WINDOW));
        else
            drop_next = (count_reg != '0);
    end

    // read-modify-write of the window state, done in ST_UPDATE
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        count_next = count_reg;
        wi_next    = wi_reg;
        mem_we     = 1'b0;
        if (state_reg == ST_UPDATE)
        begin
            if (drop_reg)
            begin
                sum_x_next = sum_x_next - SW'(rd_reg[2*C-1:C]);
                sum_y_next = sum_y_next - SW'(rd_reg[C-1:0]);
                count_next = count_next - CW'(1);
            end
            if (op_reg == pwa_pkg::OP_DETECT)
            begin
                mem_we     = 1'b1;
                sum_x_next = sum_x_next + SW'(px_reg);
                sum_y_next = sum_y_next + SW'(py_reg);
                count_next = count_next + CW'(1);
                wi_next    = (wi_reg == IW'(MAX_WINDOW - 1)) ? '0 : wi_reg + IW'(1);
            end
        end
    end

    assign div_start = (state_reg == ST_UPDATE) && (count_next != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_UPDATE;
            ST_UPDATE: state_next = div_start ? ST_DIVIDE : ST_WAIT;
            ST_DIVIDE: if (div_done) state_next = ST_WAIT;
            ST_WAIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_data_next = '0;
        if (count_reg != '0)
        begin
            out_data_next.mean_x     = C'(quot_x);
            out_data_next.mean_y     = C'(quot_y);
            out_data_next.held_count = pwa_pkg::COUNT_OUT_W'(count_reg);
            out_data_next.mean_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= pwa_pkg::LENGTH_RESET;
            wi_reg        <= '0;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                wlen_reg <= cfg_data;
            wi_reg    <= wi_next;
            count_reg <= count_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_data.opcode;
            px_reg   <= in_data.point_x;
            py_reg   <= in_data.point_y;
            drop_reg <= drop_next;
        end
        if (load_out)
            out_data_reg <= out_data_next;
    end

    // point memory: {x, y} per slot, read registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wi_reg] <= {px_reg, py_reg};
        if (accept)
            rd_reg <= mem[rd_addr];
    end

    pwa_divider #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_x (sum_x_next),
        .dividend_y (sum_y_next),
        .divisor    (count_next),
        .done       (div_done),
        .quot_x     (quot_x),
        .quot_y     (quot_y)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WINDOW))
        else $error("window count above capacity");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside divide state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall && !out_valid_reg || in_stall)
        else $error("input not stalled after transaction");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (count_reg == '0) |=>
            out_valid && !out_data.mean_valid && (out_data.mean_x == '0)
            && (out_data.mean_y == '0))
        else $error("empty window result not zero");

endmodule

FILE: sv/pwa_divider.sv
// Two-lane restoring divider, one quotient bit per lane per cycle, shared divisor.
module pwa_divider #(
    parameter int MAX_WINDOW = pwa_pkg::MAX_WINDOW_D
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    start,
    input  logic [pwa_pkg::COORD_BITS+$clog2(MAX_WINDOW)-1:0]       dividend_x,
    input  logic [pwa_pkg::COORD_BITS+$clog2(MAX_WINDOW)-1:0]       dividend_y,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]                         divisor,
    output logic                                                    done,
    output logic [pwa_pkg::COORD_BITS+$clog2(MAX_WINDOW)-1:0]       quot_x,
    output logic [pwa_pkg::COORD_BITS+$clog2(MAX_WINDOW)-1:0]       quot_y
);

    localparam int SW  = pwa_pkg::COORD_BITS + $clog2(MAX_WINDOW);
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int SCW = $clog2(SW);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [SCW-1:0] step_reg, step_next;
    logic [CW-1:0]  div_reg;
    logic [CW-1:0]  rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [SW-1:0]  quo_x_reg, quo_x_next, quo_y_reg, quo_y_next;
    logic [CW:0]    shift_x, shift_y;

    always_comb
    begin
        shift_x    = {rem_x_reg, quo_x_reg[SW-1]};
        shift_y    = {rem_y_reg, quo_y_reg[SW-1]};
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        quo_x_next = quo_x_reg;
        quo_y_next = quo_y_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        if (start)
        begin
            rem_x_next = '0;
            rem_y_next = '0;
            quo_x_next = dividend_x;
            quo_y_next = dividend_y;
            busy_next  = 1'b1;
            step_next  = '0;
        end
        else if (busy_reg)
        begin
            if (shift_x >= {1'b0, div_reg})
            begin
                rem_x_next = CW'(shift_x - {1'b0, div_reg});
                quo_x_next = {quo_x_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_x_next = CW'(shift_x);
                quo_x_next = {quo_x_reg[SW-2:0], 1'b0};
            end
            if (shift_y >= {1'b0, div_reg})
            begin
                rem_y_next = CW'(shift_y - {1'b0, div_reg});
                quo_y_next = {quo_y_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_y_next = CW'(shift_y);
                quo_y_next = {quo_y_reg[SW-2:0], 1'b0};
            end
            step_next = step_reg + SCW'(1);
            if (step_reg == SCW'(SW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            div_reg <= divisor;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        quo_x_reg <= quo_x_next;
        quo_y_reg <= quo_y_next;
    end

    assign done   = done_reg;
    assign quot_x = quo_x_reg;
    assign quot_y = quo_y_reg;

endmodule
